// ----- hw/rtl/sfsg_pkg.sv -----
// shared types and constants for the stadium fill span generator
package sfsg_pkg;

  localparam int unsigned XW   = 12;  // column width
  localparam int unsigned YW   = 12;  // origin row width
  localparam int unsigned BWW  = 12;  // body width field
  localparam int unsigned HTW  = 8;   // height field
  localparam int unsigned CW   = 32;  // color width
  localparam int unsigned LW   = 13;  // span length width
  localparam int unsigned RW   = 13;  // row width
  localparam int unsigned OW   = 26;  // linear offset width
  localparam int unsigned BMW  = 13;  // bitmap width register

  localparam logic [BMW-1:0] BITMAP_WIDTH_RESET = 13'd64;
  localparam logic [LW-1:0]  SPAN_LEN_MAX       = 13'd8191;

  typedef struct packed {
    logic [XW-1:0]  orig_x;
    logic [YW-1:0]  orig_y;
    logic [BWW-1:0] body_width;
    logic [HTW-1:0] height;
    logic [CW-1:0]  fill_color;
  } sfsg_in_t;

  typedef struct packed {
    logic [XW-1:0] x_start;
    logic [LW-1:0] span_length;
    logic [RW-1:0] row_top;
    logic [RW-1:0] row_bottom;
    logic [OW-1:0] offset_top;
    logic [OW-1:0] offset_bottom;
    logic [CW-1:0] span_color;
    logic          last_span;
  } sfsg_out_t;

  typedef struct packed {
    logic load_cmd;   // latch a new command
    logic sq_init;    // load the radicand for the current step
    logic sq_step;    // one root digit
    logic calc;       // span geometry and offset products
    logic load_out;   // move the span into the output register
    logic next_step;  // advance to the next step
  } sfsg_cmd_t;

  typedef struct packed {
    logic h_zero;
    logic is_last;
    logic out_free;
  } sfsg_sts_t;

endpackage

// ----- hw/rtl/sfsg_ctrl.sv -----
// sequencer for the span generator: command, root digits, span calc, emit
module sfsg_ctrl #(
  parameter int unsigned SqIters = 7
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  sfsg_pkg::sfsg_sts_t sts_i,
  output sfsg_pkg::sfsg_cmd_t cmd_o
);
  import sfsg_pkg::*;

  localparam int unsigned IW = (SqIters > 1) ? $clog2(SqIters) : 1;
  localparam logic [IW-1:0] IterLast = IW'(SqIters - 1);

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SETUP = 5'b00010,
    ST_SQRT  = 5'b00100,
    ST_CALC  = 5'b01000,
    ST_EMIT  = 5'b10000
  } state_e;

  state_e        state_q, state_d;
  logic [IW-1:0] iter_q, iter_d;

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load_cmd = 1'b1;
          state_d        = ST_SETUP;
        end
      end
      ST_SETUP: begin
        if (sts_i.h_zero) begin
          state_d = ST_IDLE;
        end else begin
          cmd_o.sq_init = 1'b1;
          iter_d        = '0;
          state_d       = ST_SQRT;
        end
      end
      ST_SQRT: begin
        cmd_o.sq_step = 1'b1;
        iter_d        = iter_q + IW'(1);
        if (iter_q == IterLast) begin
          state_d = ST_CALC;
        end
      end
      ST_CALC: begin
        cmd_o.calc = 1'b1;
        state_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          if (sts_i.is_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.next_step = 1'b1;
            state_d         = ST_SETUP;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign in_ready_o = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      iter_q  <= '0;
    end else begin
      state_q <= state_d;
      iter_q  <= iter_d;
    end
  end

endmodule

// ----- hw/rtl/sfsg_datapath.sv -----
// command registers, digit-by-digit square root, span math and output register
module sfsg_datapath #(
  parameter int unsigned MaxHeight = 128,
  parameter int unsigned HW        = 7,
  parameter int unsigned SqIters   = 7
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  sfsg_pkg::sfsg_cmd_t   cmd_i,
  output sfsg_pkg::sfsg_sts_t   sts_o,
  input  sfsg_pkg::sfsg_in_t    in_data_i,
  input  logic                  cfg_we_i,
  input  logic [sfsg_pkg::BMW-1:0] cfg_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sfsg_pkg::sfsg_out_t   out_data_o
);
  import sfsg_pkg::*;

  localparam int unsigned VW = 2 * HW;
  localparam logic [VW-1:0] BitInit = VW'(1) << (2 * (SqIters - 1));
  localparam logic [HTW-1:0] HtMax = HTW'(MaxHeight);

  logic [BMW-1:0] bmw_q;
  logic [XW-1:0]  ox_q;
  logic [YW-1:0]  oy_q;
  logic [BWW-1:0] bw_q;
  logic [HW-1:0]  h_q, s_q;
  logic [CW-1:0]  color_q;

  logic [VW-1:0]  rem_q, root_q, bit_q;

  logic [XW-1:0]  xs_q;
  logic [LW-1:0]  len_q;
  logic [RW-1:0]  rt_q, rb_q;
  logic [OW-1:0]  pt_q, pb_q;
  logic           last_q;

  logic           out_valid_q;
  sfsg_out_t      out_q;

  // command decode
  logic [HTW-1:0] ht_clamp;
  logic [HW-1:0]  h_new;
  assign ht_clamp = (in_data_i.height > HtMax) ? HtMax : in_data_i.height;
  assign h_new    = HW'(ht_clamp >> 1);

  // radicand and root digit
  logic [VW-1:0] hsq, ssq, trial;
  assign hsq   = VW'(h_q) * VW'(h_q);
  assign ssq   = VW'(s_q) * VW'(s_q);
  assign trial = root_q + bit_q;

  // span geometry
  logic [XW-1:0]  a_ext, xs_d;
  logic [XW+1:0]  sum_d;
  logic [LW-1:0]  len_d;
  logic [RW-1:0]  rt_d, rb_d;
  assign a_ext = XW'(root_q[HW-1:0]);
  assign xs_d  = (a_ext > ox_q) ? '0 : ox_q - a_ext;
  assign sum_d = (XW+2)'(ox_q) + (XW+2)'(bw_q) + (XW+2)'(a_ext) - (XW+2)'(xs_d);
  assign len_d = (sum_d > (XW+2)'(SPAN_LEN_MAX)) ? SPAN_LEN_MAX : LW'(sum_d);
  assign rt_d  = RW'(oy_q) + RW'(h_q) - RW'(s_q);
  assign rb_d  = RW'(oy_q) + RW'(h_q) + RW'(s_q);

  logic is_last;
  assign is_last = ((HW+1)'(s_q) + (HW+1)'(1)) == (HW+1)'(h_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bmw_q <= BITMAP_WIDTH_RESET;
    end else if (cfg_we_i) begin
      bmw_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_cmd) begin
      ox_q    <= in_data_i.orig_x;
      oy_q    <= in_data_i.orig_y;
      bw_q    <= in_data_i.body_width;
      h_q     <= h_new;
      color_q <= in_data_i.fill_color;
      s_q     <= '0;
    end else if (cmd_i.next_step) begin
      s_q <= s_q + HW'(1);
    end

    if (cmd_i.sq_init) begin
      rem_q  <= hsq - ssq;
      root_q <= '0;
      bit_q  <= BitInit;
    end else if (cmd_i.sq_step) begin
      if (rem_q >= trial) begin
        rem_q  <= rem_q - trial;
        root_q <= (root_q >> 1) + bit_q;
      end else begin
        root_q <= root_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end

    if (cmd_i.calc) begin
      xs_q   <= xs_d;
      len_q  <= len_d;
      rt_q   <= rt_d;
      rb_q   <= rb_d;
      pt_q   <= OW'(rt_d) * OW'(bmw_q);
      pb_q   <= OW'(rb_d) * OW'(bmw_q);
      last_q <= is_last;
    end

    if (cmd_i.load_out) begin
      out_q.x_start       <= xs_q;
      out_q.span_length   <= len_q;
      out_q.row_top       <= rt_q;
      out_q.row_bottom    <= rb_q;
      out_q.offset_top    <= pt_q + OW'(xs_q);
      out_q.offset_bottom <= pb_q + OW'(xs_q);
      out_q.span_color    <= color_q;
      out_q.last_span     <= last_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign sts_o.h_zero   = (h_q == '0);
  assign sts_o.is_last  = last_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- hw/rtl/stadium_fill_span_generator.sv -----
// top level of the stadium fill span generator
//
//   channel | direction | handshake             | word
//   --------+-----------+-----------------------+----------------------------
//   in      | input     | in_valid_i/in_ready_o | fill command (sfsg_in_t)
//   out     | output    | out_valid_o/out_ready_i | one span (sfsg_out_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | bitmap_width, 13 bits
//
// each span runs these steps in order: loading the radicand, the root digits in
// the shared square root loop, geometry and offset products, and handing the span
// to the output register. a command is accepted from idle and yields height/2
// spans, height clamped to MAX_HEIGHT; height below 2 gives no span and the block
// returns to idle from its setup step.
// a new command is taken while the final span still waits in the output register.
// a stalled output holds the sequencer in its emit step; reset needs no sweep.
module stadium_fill_span_generator #(
  parameter int unsigned MAX_HEIGHT = 128
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  sfsg_pkg::sfsg_in_t        in_data_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output sfsg_pkg::sfsg_out_t       out_data_o,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [sfsg_pkg::BMW-1:0]  cfg_data_i
);
  import sfsg_pkg::*;

  localparam int unsigned HalfMax = MAX_HEIGHT / 2;
  localparam int unsigned HW      = $clog2(HalfMax + 1);
  localparam int unsigned SqIters = HW;

  sfsg_cmd_t cmd;
  sfsg_sts_t sts;

  assign cfg_ready_o = 1'b1;

  sfsg_ctrl #(
    .SqIters (SqIters)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  sfsg_datapath #(
    .MaxHeight (MAX_HEIGHT),
    .HW        (HW),
    .SqIters   (SqIters)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ----- hw/rtl/sfsg_checker.sv -----
// port-level assertions for the stadium fill span generator, bound to the top
module sfsg_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_ready_o,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sfsg_pkg::sfsg_out_t out_data_o
);
  import sfsg_pkg::*;

  // output word is held while stalled
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("output word changed or dropped while stalled");

  // one command at a time: busy right after accept
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("command accepted while previous one still in work");

  // a fresh span needs the square root loop first
  a_no_instant_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o |=> !out_valid_o)
    else $error("span appeared right after command accept");

  // while a non-final span waits, the command is not finished
  a_mid_cmd_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.last_span |-> !in_ready_o)
    else $error("ready for a new command in the middle of a span sequence");

  // after a final span is taken with no new command, nothing more comes out
  a_quiet_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && out_data_o.last_span && in_ready_o && !in_valid_i
    |=> !out_valid_o)
    else $error("span emitted after the final span of a command");

endmodule

bind stadium_fill_span_generator sfsg_checker u_sfsg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_data_o  (out_data_o)
);

// ----- tb/tb_stadium_fill_span_generator.sv -----
// self-checking testbench for the stadium fill span generator
`timescale 1ns / 1ps

module tb_stadium_fill_span_generator;
  import sfsg_pkg::*;

  localparam int unsigned MAX_H  = 128;
  localparam int unsigned SETTLE = 16;         // covers a no-span command and one span
  localparam int unsigned LIMIT  = 1_000_000;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  sfsg_in_t         in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  sfsg_out_t        out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [BMW-1:0]   cfg_data_i  = '0;

  sfsg_out_t        pending_spans[$];
  logic [BMW-1:0]   cur_bitmap_width = BITMAP_WIDTH_RESET;
  bit               bursty = 1'b0;
  int unsigned      error_count = 0;
  int unsigned      cycles = 0;

  stadium_fill_span_generator #(
    .MAX_HEIGHT (MAX_H)
  ) DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // floor of the square root, by counting up
  function automatic int unsigned arc_extent(input int unsigned r2);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= r2) r++;
    return r;
  endfunction

  function automatic void predict_spans(input sfsg_in_t c);
    int unsigned ht, h, a, xs, len, rt, rb, ot, ob;
    sfsg_out_t   sp;
    ht = c.height;
    if (ht > MAX_H) ht = MAX_H;
    h = ht / 2;
    for (int unsigned s = 0; s < h; s++) begin
      a  = arc_extent(h * h - s * s);
      xs = (a > c.orig_x) ? 0 : c.orig_x - a;
      // right end stays put when the left end clips
      len = c.orig_x + c.body_width + a - xs;
      if (len > SPAN_LEN_MAX) len = SPAN_LEN_MAX;
      rt = c.orig_y + h - s;
      rb = c.orig_y + h + s;
      ot = rt * cur_bitmap_width + xs;
      ob = rb * cur_bitmap_width + xs;
      sp.x_start       = xs[XW-1:0];
      sp.span_length   = len[LW-1:0];
      sp.row_top       = rt[RW-1:0];
      sp.row_bottom    = rb[RW-1:0];
      sp.offset_top    = ot[OW-1:0];
      sp.offset_bottom = ob[OW-1:0];
      sp.span_color    = c.fill_color;
      sp.last_span     = (s + 1 == h);
      pending_spans.push_back(sp);
    end
  endfunction

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
    end
  endtask

  always @(posedge clk_i) begin
    sfsg_out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_spans.size() == 0) begin
        $error("span word with nothing pending: %p", out_data_o);
        error_count++;
      end else begin
        want = pending_spans.pop_front();
        check_field("x_start",       want.x_start,       out_data_o.x_start);
        check_field("span_length",   want.span_length,   out_data_o.span_length);
        check_field("row_top",       want.row_top,       out_data_o.row_top);
        check_field("row_bottom",    want.row_bottom,    out_data_o.row_bottom);
        check_field("offset_top",    want.offset_top,    out_data_o.offset_top);
        check_field("offset_bottom", want.offset_bottom, out_data_o.offset_bottom);
        check_field("span_color",    want.span_color,    out_data_o.span_color);
        check_field("last_span",     want.last_span,     out_data_o.last_span);
      end
    end
  end

  // output back-pressure in bursts
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (bursty && $urandom_range(0, 5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  task automatic send_cmd(input sfsg_in_t cmd);
    if (bursty && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= cmd;
    do @(posedge clk_i); while (!in_ready_o);
    predict_spans(cmd);
  endtask

  // stop sending and let every pending span drain out
  task automatic settle_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_spans.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_bitmap_width(input logic [BMW-1:0] w);
    settle_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= w;
    do @(posedge clk_i); while (!cfg_ready_o);
    cur_bitmap_width = w;
    cfg_valid_i <= 1'b0;
  endtask

  function automatic sfsg_in_t make_cmd(input int unsigned ox, oy, bw, ht,
                                        input logic [CW-1:0] col);
    sfsg_in_t c;
    c.orig_x     = XW'(ox);
    c.orig_y     = YW'(oy);
    c.body_width = BWW'(bw);
    c.height     = HTW'(ht);
    c.fill_color = col;
    return c;
  endfunction

  function automatic sfsg_in_t rand_cmd();
    sfsg_in_t c;
    c.orig_x     = XW'($urandom);
    c.orig_y     = YW'($urandom);
    c.body_width = BWW'($urandom);
    c.fill_color = $urandom;
    case ($urandom_range(0, 9))
      0:       c.height = HTW'($urandom_range(0, 3));
      1:       c.height = HTW'($urandom_range(129, 255));
      2:       c.height = HTW'($urandom_range(120, 128));
      default: c.height = HTW'($urandom_range(4, 64));
    endcase
    if ($urandom_range(0, 3) == 0) c.orig_x = XW'($urandom_range(0, 70));
    if ($urandom_range(0, 7) == 0) c.body_width = '0;
    // push the span length toward saturation
    if ($urandom_range(0, 9) == 0) begin
      c.orig_x     = XW'($urandom_range(4000, 4095));
      c.body_width = BWW'($urandom_range(4000, 4095));
    end
    return c;
  endfunction

  task automatic test_reset_width();
    send_cmd(make_cmd(100, 10, 5, 0, 32'h1234_5678));
    send_cmd(make_cmd(100, 10, 5, 1, 32'h8765_4321));
    send_cmd(make_cmd(50, 0, 3, 2, 32'hA5A5_A5A5));
    send_cmd(make_cmd(50, 0, 3, 3, 32'h5A5A_5A5A));
    send_cmd(make_cmd(2048, 100, 10, 128, 32'h0000_0000));
    send_cmd(make_cmd(0, 7, 0, 255, 32'hFFFF_FFFF));
    send_cmd(make_cmd(4095, 4095, 4095, 128, 32'hDEAD_BEEF));
    send_cmd(make_cmd(30, 200, 1, 100, 32'h0F0F_0F0F));
    send_cmd(make_cmd(1000, 3000, 4095, 129, 32'hF0F0_F0F0));
    send_cmd(make_cmd(0, 0, 0, 7, 32'h0000_0001));
  endtask

  task automatic test_width_extremes();
    bursty = 1'b1;
    write_bitmap_width('0);
    send_cmd(make_cmd(10, 20, 30, 40, 32'h1111_1111));
    send_cmd(make_cmd(4095, 4095, 0, 128, 32'h2222_2222));
    write_bitmap_width('1);
    send_cmd(make_cmd(4095, 4095, 4095, 128, 32'h3333_3333));
    send_cmd(make_cmd(3, 0, 0, 20, 32'h4444_4444));
    write_bitmap_width(BMW'(1));
    send_cmd(make_cmd(500, 600, 700, 64, 32'h5555_5555));
    write_bitmap_width(BMW'(4096));
    send_cmd(make_cmd(4095, 4095, 17, 127, 32'h6666_6666));
  endtask

  task automatic test_random_commands();
    logic [BMW-1:0] w;
    for (int ph = 0; ph < 5; ph++) begin
      case ($urandom_range(0, 5))
        0:       w = '0;
        1:       w = '1;
        default: w = BMW'($urandom_range(1, 4096));
      endcase
      write_bitmap_width(w);
      // the last phase runs with no gaps and no stalls
      bursty = (ph != 4);
      for (int i = 0; i < 20; i++) send_cmd(rand_cmd());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_width();
    test_width_extremes();
    test_random_commands();
    settle_idle();
    if (error_count == 0 && pending_spans.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
